// ===== rtl/core/ces_pkg.sv =====
package ces_pkg;

   localparam int MAX_EVENTS_DEF = 64;
   localparam int FAR_AWAY       = 3000;
   localparam int BEYOND_DAY     = 1441;
   localparam int DAY_MINUTES    = 1440;
   localparam int FORCED_GRACE   = 2;

   localparam int F_FORCED  = 0;
   localparam int F_SKIP    = 1;
   localparam int F_BBS     = 2;
   localparam int F_NOREQ   = 3;
   localparam int F_NOOUT   = 4;
   localparam int F_DYNAMIC = 5;

   localparam logic [1:0] CMD_WRITE  = 2'd0;
   localparam logic [1:0] CMD_FIND   = 2'd1;
   localparam logic [1:0] CMD_NEXT   = 2'd2;
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   localparam logic REG_EVENT_COUNT   = 1'b0;
   localparam logic REG_NO_FORCE_LATE = 1'b1;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [5:0]  entry_index;
      logic [10:0] minute;
      logic [10:0] duration;
      logic [6:0]  weekday_mask;
      logic [4:0]  month_day;
      logic [3:0]  month;
      logic [5:0]  event_flags;
      logic [4:0]  init_day_ran;
      logic [2:0]  weekday;
      logic        skip_board;
   } req_type;

   typedef struct packed {
      logic        event_found;
      logic [5:0]  event_index;
      logic        event_started;
      logic        take_requests;
      logic        outbound_requests_ok;
      logic        next_found;
      logic [5:0]  next_index;
      logic [10:0] minutes_to_next;
   } rsp_type;

   typedef struct packed {
      logic [10:0] minute;
      logic [10:0] duration;
      logic [6:0]  days;
      logic [4:0]  mday;
      logic [3:0]  month;
      logic [5:0]  flags;
      logic [4:0]  day_ran;
   } entry_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FIND_RD,
      ST_FIND_EV,
      ST_CLR_RD,
      ST_CLR_WR,
      ST_NEXT_RD,
      ST_NEXT_EV,
      ST_TMR_RD,
      ST_TMR_EV,
      ST_DONE
   } state_type;

endpackage

// ===== rtl/core/ces_table.sv =====
module ces_table
   import ces_pkg::*;
#(
   parameter int MAX_EVENTS = MAX_EVENTS_DEF,
   localparam int AW = (MAX_EVENTS > 1) ? $clog2(MAX_EVENTS) : 1
) (
   input  logic      clock,
   input  logic      rd_en,
   input  logic [AW-1:0] rd_addr,
   input  logic      wr_en,
   input  logic [AW-1:0] wr_addr,
   input  entry_type wr_data,
   output entry_type rd_data
);

   entry_type mem [MAX_EVENTS];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ===== rtl/core/calendar_event_scheduler.sv =====
// calendar event scheduler: a 64-entry (MAX_EVENTS) event table in one
// synchronous memory, walked by a sequencer that reads each entry in one
// state and evaluates it in the next. start is taken only while busy is low;
// each command gives exactly one result beat on rsp_valid, held for one cycle,
// which the receiver must take: it cannot stall the block. the result beat
// sits in the first cycle with busy low again. a write or an unused command
// goes straight to its result. a find reads entries in order until one hits,
// plus a skip-clearing pass over the entries when the hit starts an event. a
// next query scans every entry, plus a next-day pass when the best guess for
// today is BEYOND_DAY or more; the scans cover N entries, N being event_count
// saturated to MAX_EVENTS. the table has no reset and must be written before
// the entries below event_count are queried.
module calendar_event_scheduler
   import ces_pkg::*;
#(
   parameter int MAX_EVENTS = MAX_EVENTS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  req_type    req_data,
   output logic       rsp_valid,
   output rsp_type    rsp_data,
   input  logic       csr_we,
   input  logic       csr_index,
   input  logic [6:0] csr_wdata
);

   localparam int AW = (MAX_EVENTS > 1) ? $clog2(MAX_EVENTS) : 1;
   localparam int CW = $clog2(MAX_EVENTS + 1);

   state_type state_ff, state_in;

   // configuration
   logic [6:0] event_count_ff;
   logic       no_force_late_ff;
   logic [CW-1:0] scan_n;

   // query context
   req_type    req_ff;
   logic [CW-1:0] idx_ff, idx_in;
   logic       act_valid_ff, act_valid_in;
   logic [AW-1:0] act_idx_ff, act_idx_in;
   logic signed [12:0] best_ff, best_in;
   logic        found_ff, found_in;
   logic [AW-1:0] best_idx_ff, best_idx_in;
   rsp_type     rsp_ff, rsp_in;
   logic        rsp_valid_ff, rsp_valid_in;

   logic        mem_rd_en, mem_wr_en;
   logic [AW-1:0] mem_rd_addr, mem_wr_addr;
   entry_type   mem_wr_data, e;

   ces_table #(.MAX_EVENTS(MAX_EVENTS)) u_table (
      .clock   (clock),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_data (e)
   );

   assign scan_n = (event_count_ff > 7'(MAX_EVENTS)) ? CW'(MAX_EVENTS)
                                                     : CW'(event_count_ff);
   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // per-entry evaluation of the current entry
   logic [7:0]  today, tmrw;
   logic        date_ok, day_ok, tmr_ok;
   logic signed [12:0] diff;
   logic        in_win, overdue, find_hit, find_mark, find_start;
   logic        nx_ok;
   logic signed [12:0] nx_guess, tm_guess;
   logic [10:0] now;

   always_comb begin
      now   = req_ff.minute;
      today = (req_ff.weekday < 3'd7) ? (8'd1 << req_ff.weekday) : 8'd0;
      tmrw  = (req_ff.weekday < 3'd6) ? (8'd1 << (req_ff.weekday + 3'd1)) : 8'd1;
      date_ok = (e.mday == 5'd0 || e.mday == req_ff.month_day) &&
                (e.month == 4'd0 || e.month == req_ff.month);
      day_ok  = |(today[6:0] & e.days);
      tmr_ok  = |(tmrw[6:0] & e.days);
      diff    = $signed({2'b00, now}) - $signed({2'b00, e.minute});
      in_win  = (diff < $signed({2'b00, e.duration})) ||
                (diff == 13'sd0 && e.duration == 11'd0) ||
                (e.flags[F_FORCED] && e.day_ran != req_ff.month_day);
      overdue = diff > $signed({2'b00, e.duration});
      find_hit   = 1'b0;
      find_mark  = 1'b0;
      find_start = 1'b0;
      if (!diff[12] && day_ok && date_ok && in_win) begin
         if (overdue && no_force_late_ff) begin
            find_mark = 1'b1;
         end else if (e.day_ran != req_ff.month_day) begin
            find_start = 1'b1;
            find_hit   = 1'b1;
         end else if (!e.flags[F_SKIP]) begin
            find_hit = 1'b1;
         end
      end
      nx_ok = !(act_valid_ff && act_idx_ff == idx_ff[AW-1:0]) &&
              !(req_ff.skip_board && e.flags[F_BBS]) &&
              e.day_ran != req_ff.month_day && day_ok && date_ok &&
              (e.minute > now || e.flags[F_FORCED]);
      nx_guess = (e.minute > now) ? -diff : $signed(13'(FORCED_GRACE));
      // goes negative when the query minute exceeds the entry minute plus a full day
      tm_guess = $signed({2'b00, e.minute}) + $signed(13'(DAY_MINUTES)) -
                 $signed({2'b00, now});
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               unique case (req_data.cmd)
                  CMD_FIND: state_in = ST_FIND_RD;
                  CMD_NEXT: state_in = ST_NEXT_RD;
                  default:  state_in = ST_DONE;
               endcase
            end
         end
         ST_FIND_RD: state_in = (idx_ff >= scan_n) ? ST_DONE : ST_FIND_EV;
         ST_FIND_EV: begin
            if (find_start)    state_in = ST_CLR_RD;
            else if (find_hit) state_in = ST_DONE;
            else               state_in = ST_FIND_RD;
         end
         ST_CLR_RD:  state_in = (idx_ff >= scan_n) ? ST_DONE : ST_CLR_WR;
         ST_CLR_WR:  state_in = ST_CLR_RD;
         ST_NEXT_RD: begin
            if (idx_ff < scan_n)                          state_in = ST_NEXT_EV;
            else if (best_ff >= $signed(13'(BEYOND_DAY))) state_in = ST_TMR_RD;
            else                                          state_in = ST_DONE;
         end
         ST_NEXT_EV: state_in = ST_NEXT_RD;
         ST_TMR_RD:  state_in = (idx_ff >= scan_n) ? ST_DONE : ST_TMR_EV;
         ST_TMR_EV:  state_in = ST_TMR_RD;
         ST_DONE:    state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      idx_in       = idx_ff;
      act_valid_in = act_valid_ff;
      act_idx_in   = act_idx_ff;
      best_in      = best_ff;
      found_in     = found_ff;
      best_idx_in  = best_idx_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = 1'b0;
      mem_rd_en    = 1'b0;
      mem_rd_addr  = idx_ff[AW-1:0];
      mem_wr_en    = 1'b0;
      mem_wr_addr  = idx_ff[AW-1:0];
      mem_wr_data  = e;
      unique case (state_ff)
         ST_IDLE: begin
            idx_in   = '0;
            best_in  = $signed(13'(FAR_AWAY));
            found_in = 1'b0;
            best_idx_in = '0;
            rsp_in   = '0;
            if (start && req_data.cmd == CMD_WRITE &&
                32'(req_data.entry_index) < MAX_EVENTS) begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = req_data.entry_index[AW-1:0];
               mem_wr_data = '{minute: req_data.minute, duration: req_data.duration,
                               days: req_data.weekday_mask, mday: req_data.month_day,
                               month: req_data.month, flags: req_data.event_flags,
                               day_ran: req_data.init_day_ran};
            end
            if (start && req_data.cmd == CMD_FIND) begin
               act_valid_in = 1'b0;
            end
         end
         ST_FIND_RD, ST_CLR_RD, ST_NEXT_RD, ST_TMR_RD: begin
            mem_rd_en = (idx_ff < scan_n);
            if (state_ff == ST_NEXT_RD && idx_ff >= scan_n) begin
               idx_in = '0;
            end
         end
         ST_FIND_EV: begin
            idx_in = idx_ff + CW'(1);
            if (find_mark || find_start) begin
               mem_wr_en = 1'b1;
               mem_wr_data.day_ran = req_ff.month_day;
               if (find_start) mem_wr_data.flags[F_SKIP] = 1'b0;
            end
            if (find_hit) begin
               act_valid_in = 1'b1;
               act_idx_in   = idx_ff[AW-1:0];
               rsp_in.event_found   = 1'b1;
               rsp_in.event_index   = 6'(idx_ff);
               rsp_in.event_started = find_start;
               rsp_in.take_requests = !e.flags[F_NOREQ];
               rsp_in.outbound_requests_ok = !e.flags[F_NOOUT];
            end
            if (find_start) idx_in = '0;
         end
         ST_CLR_WR: begin
            idx_in = idx_ff + CW'(1);
            if (!e.flags[F_DYNAMIC]) begin
               mem_wr_en = 1'b1;
               mem_wr_data.flags[F_SKIP] = 1'b0;
            end
         end
         ST_NEXT_EV: begin
            idx_in = idx_ff + CW'(1);
            if (nx_ok && best_ff > nx_guess) begin
               best_in = nx_guess;
               best_idx_in = idx_ff[AW-1:0];
               found_in = 1'b1;
            end
         end
         ST_TMR_EV: begin
            idx_in = idx_ff + CW'(1);
            if (!(req_ff.skip_board && e.flags[F_BBS]) && tmr_ok && date_ok &&
                best_ff > tm_guess) begin
               best_in = tm_guess;
               best_idx_in = idx_ff[AW-1:0];
               found_in = 1'b1;
            end
         end
         ST_DONE: begin
            rsp_valid_in = 1'b1;
            if (req_ff.cmd == CMD_NEXT) begin
               rsp_in.next_found = found_ff;
               rsp_in.next_index = found_ff ? 6'(best_idx_ff) : 6'd0;
               rsp_in.minutes_to_next =
                  (best_ff > $signed(13'(DAY_MINUTES))) ? 11'(DAY_MINUTES)
                  : (best_ff < 13'sd1) ? 11'd1 : best_ff[10:0];
            end
         end
         default: begin end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         event_count_ff   <= '0;
         no_force_late_ff <= 1'b0;
         act_valid_ff     <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         act_valid_ff <= act_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               REG_EVENT_COUNT:   event_count_ff   <= csr_wdata;
               REG_NO_FORCE_LATE: no_force_late_ff <= csr_wdata[0];
               default: begin end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && start) begin
         req_ff <= req_data;
      end
      idx_ff      <= idx_in;
      act_idx_ff  <= act_idx_in;
      best_ff     <= best_in;
      found_ff    <= found_in;
      best_idx_ff <= best_idx_in;
      rsp_ff      <= rsp_in;
   end

`ifndef NO_ASSERTIONS
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(state_ff) == ST_DONE) else $error("stray response");
   a_idle_after_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !busy) else $error("busy with response");
   a_best_bound: assert property (@(posedge clock) disable iff (reset)
      found_ff |-> best_ff <= $signed(13'(FAR_AWAY))) else $error("best out of range");
`endif

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

import ces_pkg::*;

// scheduler predictor plus the queue of replies it expects
class sched_scoreboard;
   entry_type  tab[64];
   logic       act_valid;
   logic [5:0] act_idx;
   int         count_reg;
   logic       nfl_reg;
   rsp_type    pending[$];
   int         errors;
   int         n_found, n_started, n_next;

   function new();
      act_valid = 0;
      act_idx = 0;
      count_reg = 0;
      nfl_reg = 0;
      errors = 0;
      n_found = 0;
      n_started = 0;
      n_next = 0;
      foreach (tab[i]) tab[i] = '0;
   endfunction

   function void set_reg(logic idx, logic [6:0] val);
      if (idx == REG_EVENT_COUNT) count_reg = int'(val);
      else nfl_reg = val[0];
   endfunction

   function bit date_match(entry_type e, logic [4:0] md, logic [3:0] mo);
      return (e.mday == 0 || e.mday == md) && (e.month == 0 || e.month == mo);
   endfunction

   // note an accepted beat and work out its reply
   function void note_command(req_type r);
      rsp_type    x;
      int         n, diff, len, best, guess, nmin;
      logic [6:0] today, tomorrow;
      entry_type  e;
      bit         started, found;
      int         idx;
      x = '0;
      n = (count_reg > 64) ? 64 : count_reg;
      today = (r.weekday < 7) ? (7'd1 << r.weekday) : 7'd0;
      tomorrow = (r.weekday < 6) ? (7'd1 << (r.weekday + 1)) : 7'd1;
      case (r.cmd)
         CMD_WRITE: begin
            tab[r.entry_index] = '{r.minute, r.duration, r.weekday_mask, r.month_day,
                                   r.month, r.event_flags, r.init_day_ran};
         end
         CMD_FIND: begin
            act_valid = 0;
            for (int i = 0; i < n; i++) begin
               e = tab[i];
               diff = int'(r.minute) - int'(e.minute);
               len = int'(e.duration);
               started = 0;
               if (diff < 0) continue;
               if ((today & e.days) == 0 || !date_match(e, r.month_day, r.month)) continue;
               if (!(diff < len || (diff == 0 && len == 0) ||
                     (e.flags[F_FORCED] && e.day_ran != r.month_day)))
                  continue;
               // overdue forced event with late starts disabled: mark as run
               if (diff > len && nfl_reg) begin
                  tab[i].day_ran = r.month_day;
                  continue;
               end
               if (e.day_ran != r.month_day) begin
                  tab[i].day_ran = r.month_day;
                  tab[i].flags[F_SKIP] = 0;
                  for (int j = 0; j < n; j++)
                     if (!tab[j].flags[F_DYNAMIC]) tab[j].flags[F_SKIP] = 0;
                  started = 1;
               end else if (e.flags[F_SKIP]) begin
                  continue;
               end
               act_valid = 1;
               act_idx = 6'(i);
               x.event_found = 1;
               x.event_index = 6'(i);
               x.event_started = started;
               x.take_requests = !tab[i].flags[F_NOREQ];
               x.outbound_requests_ok = !tab[i].flags[F_NOOUT];
               n_found++;
               n_started += started;
               break;
            end
         end
         CMD_NEXT: begin
            best = FAR_AWAY;
            found = 0;
            idx = 0;
            for (int i = 0; i < n; i++) begin
               e = tab[i];
               if (act_valid && act_idx == i) continue;
               if (r.skip_board && e.flags[F_BBS]) continue;
               if (e.day_ran == r.month_day) continue;
               if ((e.days & today) == 0) continue;
               if (!date_match(e, r.month_day, r.month)) continue;
               if (int'(e.minute) <= int'(r.minute)) begin
                  if (!e.flags[F_FORCED]) continue;
                  guess = FORCED_GRACE;
               end else begin
                  guess = int'(e.minute) - int'(r.minute);
               end
               if (best > guess) begin
                  best = guess;
                  idx = i;
                  found = 1;
               end
            end
            // no guess today below BEYOND_DAY: look at tomorrow, same date compare
            if (best >= BEYOND_DAY) begin
               nmin = DAY_MINUTES - int'(r.minute);
               for (int i = 0; i < n; i++) begin
                  e = tab[i];
                  if (r.skip_board && e.flags[F_BBS]) continue;
                  if ((e.days & tomorrow) == 0) continue;
                  if (!date_match(e, r.month_day, r.month)) continue;
                  guess = int'(e.minute) + nmin;
                  if (best > guess) begin
                     best = guess;
                     idx = i;
                     found = 1;
                  end
               end
            end
            if (best > DAY_MINUTES) best = DAY_MINUTES;
            if (best < 1) best = 1;
            x.next_found = found;
            x.next_index = found ? 6'(idx) : 6'd0;
            x.minutes_to_next = 11'(best);
            n_next += found;
         end
         default: ;
      endcase
      pending.push_back(x);
   endfunction

   function void field_cmp(string name, int exp_v, int act_v);
      if (exp_v != act_v) begin
         $display("%0t: mismatch on %s, expected %0d, actual %0d", $time, name, exp_v, act_v);
         errors++;
      end
   endfunction

   function void check_reply(rsp_type a);
      rsp_type x;
      if (pending.size() == 0) begin
         $display("%0t: unexpected reply beat, expected none, actual %h", $time, a);
         errors++;
         return;
      end
      x = pending.pop_front();
      field_cmp("event_found", x.event_found, a.event_found);
      field_cmp("event_index", x.event_index, a.event_index);
      field_cmp("event_started", x.event_started, a.event_started);
      field_cmp("take_requests", x.take_requests, a.take_requests);
      field_cmp("outbound_requests_ok", x.outbound_requests_ok, a.outbound_requests_ok);
      field_cmp("next_found", x.next_found, a.next_found);
      field_cmp("next_index", x.next_index, a.next_index);
      field_cmp("minutes_to_next", x.minutes_to_next, a.minutes_to_next);
   endfunction
endclass

module tb_top;
   localparam int REQ_W = $bits(req_type);

   logic       clock;
   logic       reset;
   logic       start;
   logic       busy;
   req_type    req_data;
   logic       rsp_valid;
   rsp_type    rsp_data;
   logic       csr_we;
   logic       csr_index;
   logic [6:0] csr_wdata;

   sched_scoreboard sb;
   int         n_items;
   logic [10:0] anchor;   // recent event minute, queries cluster around it
   req_type    fill_beat;

   calendar_event_scheduler dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // 12 ns clock
   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   // reply beats cannot be held off, take each one at the edge that ends it
   always @(posedge clock) begin
      if (!reset && rsp_valid) sb.check_reply(rsp_data);
   end

   // one command beat; start stays high when the next beat follows at once
   task automatic issue(req_type r);
      int gap;
      req_data <= r;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      sb.note_command(r);
      n_items++;
      gap = $urandom_range(0, 6);
      if ($urandom_range(0, 3) == 0) gap = 0;   // runs of back-to-back beats
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // wait for every reply, then let the block settle before a register write
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (sb.pending.size() != 0 || busy) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(logic idx, logic [6:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      sb.set_reg(idx, val);
      csr_we <= 1'b0;
   endtask

   function automatic req_type entry_beat(logic [5:0] idx, logic [10:0] m, logic [10:0] dur,
                                          logic [6:0] days, logic [5:0] fl, logic [4:0] lr);
      req_type r;
      r = '0;
      r.cmd = CMD_WRITE;
      r.entry_index = idx;
      r.minute = m;
      r.duration = dur;
      r.weekday_mask = days;
      r.event_flags = fl;
      r.init_day_ran = lr;
      return r;
   endfunction

   function automatic req_type query_beat(logic [1:0] c, logic [10:0] m, logic [2:0] wd,
                                          logic [4:0] md, logic [3:0] mo, logic sb_bit);
      req_type r;
      r = req_type'(REQ_W'({$urandom, $urandom}));   // unused bits random
      r.cmd = c;
      r.minute = m;
      r.weekday = wd;
      r.month_day = md;
      r.month = mo;
      r.skip_board = sb_bit;
      return r;
   endfunction

   // random entry, mostly plausible schedule data with random corners
   function automatic req_type rand_entry();
      req_type r;
      r = req_type'(REQ_W'({$urandom, $urandom}));
      r.cmd = CMD_WRITE;
      if ($urandom_range(0, 9) != 0) r.minute = 11'($urandom_range(0, 1439));
      if ($urandom_range(0, 9) != 0) r.duration = ($urandom_range(0, 3) == 0) ? 11'd0 :
                                                  11'($urandom_range(1, 120));
      if ($urandom_range(0, 2) != 0) r.weekday_mask = 7'h7f;
      if ($urandom_range(0, 3) != 0) r.month_day = 0;
      if ($urandom_range(0, 3) != 0) r.month = 0;
      if ($urandom_range(0, 1) != 0) r.init_day_ran = 5'($urandom_range(1, 3));
      anchor = r.minute;
      return r;
   endfunction

   function automatic req_type rand_query();
      logic [1:0]  c;
      logic [10:0] m;
      int          k;
      k = $urandom_range(0, 99);
      c = (k < 50) ? CMD_FIND : (k < 95) ? CMD_NEXT : CMD_UNUSED;
      if ($urandom_range(0, 9) == 0) m = 11'($urandom_range(0, 2047));
      else if ($urandom_range(0, 1) == 0) m = 11'((anchor + $urandom_range(0, 10)) % 1440);
      else m = 11'($urandom_range(0, 1439));
      return query_beat(c, m,
                        ($urandom_range(0, 15) == 0) ? 3'd7 : 3'($urandom_range(0, 6)),
                        ($urandom_range(0, 15) == 0) ? 5'($urandom_range(0, 31)) :
                                                       5'($urandom_range(1, 3)),
                        ($urandom_range(0, 15) == 0) ? 4'($urandom_range(0, 15)) :
                                                       4'($urandom_range(1, 12)),
                        $urandom_range(0, 1));
   endfunction

   // event_count settings per phase, extremes included
   int counts[7] = '{64, 0, 1, 5, 16, 127, 65};

   initial begin
      sb = new();
      n_items = 0;
      anchor = 0;
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      csr_we = 1'b0;
      csr_index = REG_EVENT_COUNT;
      csr_wdata = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // fill the whole table first so no unwritten entry is ever read
      for (int i = 0; i < 64; i++) begin
         fill_beat = rand_entry();
         fill_beat.entry_index = 6'(i);
         issue(fill_beat);
      end

      // directed: field extremes, every command, forced and skip handling
      drain();
      write_reg(REG_EVENT_COUNT, 7'd4);
      write_reg(REG_NO_FORCE_LATE, 7'd0);
      issue(entry_beat(6'd0, 11'd600, 11'd0, 7'h7f, 6'h00, 5'd0));     // exact minute only
      issue(entry_beat(6'd1, 11'd100, 11'd30, 7'h7f, 6'h01, 5'd0));    // forced, overdue later
      issue(entry_beat(6'd2, 11'd1439, 11'd1440, 7'h01, 6'h3e, 5'd31)); // skip, every flag but forced
      issue(entry_beat(6'd3, 11'd0, 11'd1440, 7'h40, 6'h20, 5'd0));    // dynamic, saturday
      issue(query_beat(CMD_FIND, 11'd600, 3'd1, 5'd1, 4'd1, 1'b0));
      issue(query_beat(CMD_FIND, 11'd600, 3'd1, 5'd1, 4'd1, 1'b0));
      issue(query_beat(CMD_FIND, 11'd500, 3'd1, 5'd2, 4'd12, 1'b0));   // forced late start
      issue(query_beat(CMD_NEXT, 11'd0, 3'd0, 5'd31, 4'd1, 1'b1));
      issue(query_beat(CMD_NEXT, 11'd2047, 3'd7, 5'd0, 4'd15, 1'b0));  // past-day clamp
      issue(query_beat(CMD_FIND, 11'd2047, 3'd7, 5'd31, 4'd15, 1'b1)); // weekday seven
      issue(query_beat(CMD_NEXT, 11'd1439, 3'd6, 5'd9, 4'd6, 1'b0));   // saturday wraps
      issue(query_beat(CMD_UNUSED, 11'd5, 3'd2, 5'd1, 4'd1, 1'b0));    // unused command
      issue(query_beat(CMD_FIND, 11'd1439, 3'd0, 5'd31, 4'd1, 1'b0));
      issue(query_beat(CMD_NEXT, 11'd1300, 3'd5, 5'd4, 4'd4, 1'b0));   // nothing today
      drain();
      write_reg(REG_NO_FORCE_LATE, 7'd1);
      issue(entry_beat(6'd1, 11'd100, 11'd30, 7'h7f, 6'h01, 5'd0));
      issue(query_beat(CMD_FIND, 11'd500, 3'd1, 5'd2, 4'd3, 1'b0));    // marked run, not started
      issue(query_beat(CMD_NEXT, 11'd50, 3'd1, 5'd2, 4'd3, 1'b0));

      // random phases, each with its own register setting
      foreach (counts[p]) begin
         drain();
         write_reg(REG_EVENT_COUNT, 7'(counts[p]));
         write_reg(REG_NO_FORCE_LATE, 7'(p % 2));
         repeat (210) begin
            if ($urandom_range(0, 4) == 0) issue(rand_entry());
            else issue(rand_query());
         end
      end

      drain();
      repeat (20) @(posedge clock);
      $display("ran %0d command beats over %0d register settings", n_items, 9);
      $display("events found %0d, started %0d, upcoming events found %0d",
               sb.n_found, sb.n_started, sb.n_next);
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // watchdog
   initial begin
      #50ms;
      $display("simulation failed");
      $finish;
   end
endmodule
